>>> rtl/dgam_pkg.sv
// shared types, codes and constants for the directed graph adjacency matrix
// no dependencies; used by dgam_ctrl, dgam_dp and the top level
package dgam_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam logic [6:0] VCOUNT_RST = 7'd64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_NEXT   = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PRESENT = 3'd1;
	localparam logic [2:0] ST_ABSENT  = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch request word, read its row
		logic commit;   // write back, update count, load result word
	} dgam_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free; // result register can take a new word this cycle
	} dgam_stat_t;

endpackage

>>> rtl/dgam_ctrl.sv
// request sequencer: accept, then execute and hand result to output register
// depends on dgam_pkg
module dgam_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  dgam_pkg::dgam_stat_t stat,
	output dgam_pkg::dgam_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	assign s_tready    = (state_q == S_IDLE);
	assign cmd.capture = s_tvalid && (state_q == S_IDLE);
	assign cmd.commit  = (state_q == S_EXEC) && stat.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_EXEC)
		else $error("capture did not move to execute");

	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !stat.out_free) |=> (state_q == S_EXEC && !s_tready))
		else $error("left execute while result register was full");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.commit))
		else $error("capture and commit in the same cycle");

endmodule

>>> rtl/dgam_dp.sv
// datapath: row memory with valid flags, request registers, edge update,
// next-neighbour priority encoder, edge counter and result register; uses dgam_pkg
module dgam_dp #(
	parameter int MAX_VERTICES = dgam_pkg::MAX_VERTICES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_wdata,
	input  logic [15:0]          s_tdata,
	output logic [23:0]          m_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  dgam_pkg::dgam_cmd_t  cmd,
	output dgam_pkg::dgam_stat_t stat
);

	localparam int CW = $clog2(MAX_VERTICES);

	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [MAX_VERTICES-1:0] row_q;
	logic                    rvld_q;

	logic [1:0]  req_op_q;
	logic [5:0]  req_from_q;
	logic [6:0]  req_to_q;
	logic [6:0]  vcount_q;
	logic [12:0] edges_q;

	logic        m_tvalid_q;
	logic [2:0]  out_status_q;
	logic        out_present_q;
	logic [5:0]  out_next_q;
	logic [12:0] out_total_q;

	logic [MAX_VERTICES-1:0] row;
	logic [MAX_VERTICES-1:0] span;
	logic [MAX_VERTICES-1:0] new_row;
	logic [6:0]    n_eff;
	logic [6:0]    start;
	logic          from_ok;
	logic          to_ok_edge;
	logic          to_ok_next;
	logic          is_next;
	logic          valid;
	logic [CW-1:0] col;
	logic          present;
	logic          hit;
	logic [CW-1:0] found;
	logic          do_set;
	logic          do_clr;
	logic          wr_en;
	logic [2:0]    status;
	logic [12:0]   edges_d;

	assign stat.out_free = !m_tvalid_q || m_tready;

	// a row never written since reset reads as empty
	assign row = rvld_q ? row_q : '0;

	assign n_eff = (vcount_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_q;
	assign from_ok = {1'b0, req_from_q} < n_eff;
	assign to_ok_edge = !req_to_q[6] && (req_to_q < n_eff);
	// -1 is allowed for the search, other negatives are not
	assign to_ok_next = (req_to_q == 7'h7F) || (!req_to_q[6] && (req_to_q < n_eff));
	assign is_next = (req_op_q == dgam_pkg::OP_NEXT);
	assign valid = from_ok && (is_next ? to_ok_next : to_ok_edge);
	assign start = req_to_q + 7'd1;
	assign col = req_to_q[CW-1:0];
	assign present = row[col];

	always_comb begin
		for (int c = 0; c < MAX_VERTICES; c++) begin
			span[c] = row[c] && (7'(c) < n_eff) && (7'(c) >= start);
		end
	end

	always_comb begin
		found = '0;
		hit = 1'b0;
		for (int c = MAX_VERTICES - 1; c >= 0; c--) begin
			if (span[c]) begin
				found = CW'(c);
				hit = 1'b1;
			end
		end
	end

	assign do_set = valid && (req_op_q == dgam_pkg::OP_INSERT) && !present;
	assign do_clr = valid && (req_op_q == dgam_pkg::OP_REMOVE) && present;
	assign wr_en = cmd.commit && (do_set || do_clr);

	always_comb begin
		new_row = row;
		new_row[col] = do_set;
	end

	always_comb begin
		edges_d = edges_q;
		if (do_set) edges_d = edges_q + 13'd1;
		else if (do_clr) edges_d = edges_q - 13'd1;
	end

	always_comb begin
		status = dgam_pkg::ST_INVALID;
		if (valid) begin
			case (req_op_q)
				dgam_pkg::OP_INSERT: status = present ? dgam_pkg::ST_PRESENT : dgam_pkg::ST_OK;
				dgam_pkg::OP_REMOVE: status = present ? dgam_pkg::ST_OK : dgam_pkg::ST_ABSENT;
				dgam_pkg::OP_QUERY:  status = dgam_pkg::ST_OK;
				dgam_pkg::OP_NEXT:   status = hit ? dgam_pkg::ST_OK : dgam_pkg::ST_NONE;
				default:             status = dgam_pkg::ST_INVALID;
			endcase
		end
	end

	// row memory: one read on capture, one write on commit
	always_ff @(posedge clk) begin
		if (cmd.capture) row_q <= mem[s_tdata[CW+1:2]];
		if (wr_en) mem[req_from_q[CW-1:0]] <= new_row;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q   <= s_tdata[1:0];
			req_from_q <= s_tdata[7:2];
			req_to_q   <= s_tdata[14:8];
		end
		if (cmd.commit) begin
			out_status_q  <= status;
			out_present_q <= valid && !is_next && present;
			out_next_q    <= (valid && is_next && hit) ? 6'(found) : 6'd0;
			out_total_q   <= edges_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			rvld_q     <= 1'b0;
			edges_q    <= '0;
			vcount_q   <= dgam_pkg::VCOUNT_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.capture) rvld_q <= row_vld_q[s_tdata[CW+1:2]];
			if (wr_en) row_vld_q[req_from_q[CW-1:0]] <= 1'b1;
			if (cmd.commit) edges_q <= edges_d;
			if (cfg_we) vcount_q <= cfg_wdata;
			if (cmd.commit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {1'b0, out_total_q, out_next_q, out_present_q, out_status_q};

	a_count_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(edges_q))
		else $error("edge count moved without a commit");

	a_commit_loads_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (m_tvalid_q && out_total_q == edges_q))
		else $error("committed word not shown with current edge count");

endmodule

>>> rtl/directed_graph_adjacency_matrix.sv
// directed graph adjacency matrix, bit-row store with running edge count
// accept registers the request word and its row; commit loads the result register
// on m_tdata; one word at a time, row read then update and write back (single-port
// row memory); a full result register stalls execution
// reset: all rows read as empty through per-row valid flags, edge count 0,
// vertex_count 64; no clearing pass, the block is ready right after reset
module directed_graph_adjacency_matrix #(
	parameter int MAX_VERTICES = dgam_pkg::MAX_VERTICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,  // vertex_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // opcode[1:0], from_vertex[7:2], to_vertex[14:8], zero[15]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata     // status[2:0], edge_present[3], next_vertex[9:4],
	                                // edges_total[22:10], zero[23]
);

	dgam_pkg::dgam_cmd_t  cmd;
	dgam_pkg::dgam_stat_t stat;

	dgam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dgam_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
